// ===== design/sm4_pkg.sv =====
`timescale 1ns / 1ps

package sm4_pkg;

	localparam int WORD_W    = 32;
	localparam int ROUNDS    = 32;
	localparam int CFG_IDX_W = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0][WORD_W-1:0] quad_t;

	// Configuration register indexes
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t IDX_KEY_WORD0 = 3'd0;
	localparam cfg_idx_t IDX_KEY_WORD1 = 3'd1;
	localparam cfg_idx_t IDX_KEY_WORD2 = 3'd2;
	localparam cfg_idx_t IDX_KEY_WORD3 = 3'd3;

	typedef struct packed {
		word_t plain_word0;
		word_t plain_word1;
		word_t plain_word2;
		word_t plain_word3;
	} plain_t;

	typedef struct packed {
		word_t cipher_word0;
		word_t cipher_word1;
		word_t cipher_word2;
		word_t cipher_word3;
	} cipher_t;

	// What travels down the round pipeline: block words and key words, oldest at index 0
	typedef struct packed {
		quad_t blk;
		quad_t kreg;
	} stage_t;

	localparam word_t FK [4] = '{
		32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
	};

	localparam word_t CK [ROUNDS] = '{
		32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
		32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
		32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
		32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
		32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
		32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
		32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
		32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic word_t rotl(input word_t w, input int amt);
		rotl = (w << amt) | (w >> (WORD_W - amt));
	endfunction

	// Byte-wise S-box over a word
	function automatic word_t tau(input word_t w);
		tau = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic word_t data_mix(input word_t w);
		word_t b;
		b = tau(w);
		data_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic word_t key_mix(input word_t w);
		word_t b;
		b = tau(w);
		key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

endpackage

// ===== design/sm4_key_regs.sv =====
`timescale 1ns / 1ps

module sm4_key_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  sm4_pkg::cfg_idx_t cfg_index,
	input  sm4_pkg::word_t    cfg_data,
	output sm4_pkg::quad_t    kreg_init
);
	import sm4_pkg::*;

	quad_t key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				IDX_KEY_WORD0: key_q[0] <= cfg_data;
				IDX_KEY_WORD1: key_q[1] <= cfg_data;
				IDX_KEY_WORD2: key_q[2] <= cfg_data;
				IDX_KEY_WORD3: key_q[3] <= cfg_data;
				default: ;	// drop writes past the last key word
			endcase
		end
	end

	// Whiten the key with the system constants before the schedule
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			kreg_init[i] = key_q[i] ^ FK[i];
		end
	end

endmodule

// ===== design/sm4_stage.sv =====
`timescale 1ns / 1ps

// One pipeline stage: round key ROUND and data round ROUND-1 side by side
module sm4_stage #(
	parameter int ROUND = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  sm4_pkg::stage_t data_in,
	output logic            valid_out,
	output sm4_pkg::stage_t data_out
);
	import sm4_pkg::*;

	quad_t  kreg_nxt;
	quad_t  blk_nxt;
	logic   valid_s1;
	stage_t data_s1;

	generate
		if (ROUND < ROUNDS) begin : g_key
			word_t rk;
			assign rk = data_in.kreg[0] ^ key_mix(data_in.kreg[1] ^ data_in.kreg[2]
				^ data_in.kreg[3] ^ CK[ROUND]);
			assign kreg_nxt = {rk, data_in.kreg[3], data_in.kreg[2], data_in.kreg[1]};
		end else begin : g_key_hold
			assign kreg_nxt = data_in.kreg;
		end

		if (ROUND > 0) begin : g_data
			word_t x_new;
			// Newest key word is the previous stage's round key
			assign x_new = data_in.blk[0] ^ data_mix(data_in.blk[1] ^ data_in.blk[2]
				^ data_in.blk[3] ^ data_in.kreg[3]);
			assign blk_nxt = {x_new, data_in.blk[3], data_in.blk[2], data_in.blk[1]};
		end else begin : g_data_hold
			assign blk_nxt = data_in.blk;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			data_s1.blk  <= blk_nxt;
			data_s1.kreg <= kreg_nxt;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

// ===== design/sm4_block_encrypt.sv =====
`timescale 1ns / 1ps

// SM4 block encryption, one 128-bit block per request under a 128-bit key.
//
// Request channel: drive plain and pulse start; a request is taken at every
// rising edge with start high and busy low. busy stays low, so a new block
// may enter on every cycle.
// Result channel: done is high for one cycle with the ciphertext on cipher.
// The receiver cannot hold results off and none is needed: results leave in
// request order, one per request.
// Key port: cfg_valid/cfg_ready write key word cfg_index (0..3) with
// cfg_data; cfg_ready is always high and other indexes are dropped. Write the
// key only while no request is in flight.
// The pipeline has 33 register stages; each middle one does one S-box
// layer for the key schedule and one for the data rounds, the first only the
// key layer, the last only the data layer; throughput is one block a cycle.
// Reset clears the key to zero and empties the pipeline; a block in flight
// at reset is lost.
module sm4_block_encrypt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sm4_pkg::plain_t   plain,
	output logic              done,
	output sm4_pkg::cipher_t  cipher,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  sm4_pkg::cfg_idx_t cfg_index,
	input  sm4_pkg::word_t    cfg_data
);
	import sm4_pkg::*;

	localparam int STAGES = ROUNDS + 1;

	quad_t  kreg_init;
	logic   pipe_valid [STAGES+1];
	stage_t pipe_data  [STAGES+1];

	// Every request is taken; the pipeline never stalls
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	sm4_key_regs u_key_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.kreg_init (kreg_init)
	);

	// Feed the block and the whitened key into the first stage
	assign pipe_valid[0]       = start;
	assign pipe_data[0].blk[0] = plain.plain_word0;
	assign pipe_data[0].blk[1] = plain.plain_word1;
	assign pipe_data[0].blk[2] = plain.plain_word2;
	assign pipe_data[0].blk[3] = plain.plain_word3;
	assign pipe_data[0].kreg   = kreg_init;

	// Stage k derives round key k and runs data round k-1, so the round key
	// is always one register ahead of the data that consumes it.
	generate
		for (genvar k = 0; k < STAGES; k++) begin : g_stage
			sm4_stage #(.ROUND(k)) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.valid_in  (pipe_valid[k]),
				.data_in   (pipe_data[k]),
				.valid_out (pipe_valid[k+1]),
				.data_out  (pipe_data[k+1])
			);
		end
	endgenerate

	// Last four words leave in reversed order
	assign done                = pipe_valid[STAGES];
	assign cipher.cipher_word0 = pipe_data[STAGES].blk[3];
	assign cipher.cipher_word1 = pipe_data[STAGES].blk[2];
	assign cipher.cipher_word2 = pipe_data[STAGES].blk[1];
	assign cipher.cipher_word3 = pipe_data[STAGES].blk[0];

endmodule
